// File: rtl/core/elementary_ca_ring_step_core_macros.svh
// Assertion macros used by the ring step core
`ifndef ELEMENTARY_CA_RING_STEP_CORE_MACROS_SVH
`define ELEMENTARY_CA_RING_STEP_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define ECRS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecrs assertion failed");
// Next-cycle implication
`define ECRS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecrs assertion failed");
`else
`define ECRS_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define ECRS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/ecrs_pkg.sv
// Types and constants of the elementary CA ring step core
package ecrs_pkg;

    localparam int CELL_IDX_W = 8;
    localparam int WORD_BITS  = 64;
    localparam int WORD_IDX_W = 2;
    localparam int ROW_BITS   = 256;
    localparam int RULE_W     = 8;
    localparam int ACTIVE_W   = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int S_TDATA_W  = 16;

    localparam logic [RULE_W-1:0]   RULE_RESET   = 8'd18;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 9'd256;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_SEED  = 2'd1,
        CMD_EMIT  = 2'd2
    } ecrs_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RULE   = 2'd0,
        REG_ACTIVE = 2'd1
    } ecrs_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_COMMIT
    } ecrs_state_t;

    // One 64-cell word of the row with the cells around it and cell 0
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 left;
        logic                 right;
        logic                 head;
    } ecrs_win_t;

endpackage

// File: rtl/core/elementary_ca_ring_step_core.sv
// Elementary cellular automaton ring: command decode, sequencer and output register
//
// Keeps a ring of up to 256 one-bit cells and applies an 8-bit Wolfram rule.
// Write-cell, seed and unused commands complete in the cycle they are accepted.
// The emit command sends ceil(n/64) row words, n being active_cells clamped
// to 1..min(MAX_CELLS, 256): one shared 64-cell rule unit produces one output
// word and its next-generation word per cycle while the output does not stall,
// and a commit state then writes the new row. Output stalls hold the emit phase.
// s_tready is low while an emit is in progress. Configuration is taken any time
// and must only change while the core is idle.
`include "elementary_ca_ring_step_core_macros.svh"

module elementary_ca_ring_step_core #(
    parameter int MAX_CELLS = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // cfg_data: rule_number [7:0] or active_cells [8:0]
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ecrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ecrs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: cell_index [7:0], cell_value [8], zero [15:9]
    input  logic [ecrs_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: cmd [1:0]
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: row_word [63:0]
    output logic [ecrs_pkg::WORD_BITS-1:0]    m_tdata,
    // m_tuser: word_number [1:0]
    output logic [ecrs_pkg::WORD_IDX_W-1:0]   m_tuser,
    output logic                              m_tlast
);
    import ecrs_pkg::*;

    localparam int ROW_LIMIT = (MAX_CELLS < ROW_BITS) ? MAX_CELLS : ROW_BITS;
    localparam logic [ACTIVE_W-1:0] ROW_LIMIT_W = ACTIVE_W'(ROW_LIMIT);

    logic [RULE_W-1:0]     rule_reg;
    logic [ACTIVE_W-1:0]   active_reg;
    ecrs_state_t           state_reg, state_next;
    logic [WORD_IDX_W-1:0] word_reg, word_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [WORD_BITS-1:0]  m_tdata_reg, m_tdata_next;
    logic [WORD_IDX_W-1:0] m_tuser_reg, m_tuser_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic                  s_acc;
    ecrs_cmd_t             cmd;
    logic [ACTIVE_W-1:0]   act_m1;
    logic [CELL_IDX_W-1:0] n_m1;
    logic [ACTIVE_W-1:0]   n_len;
    logic [WORD_IDX_W-1:0] last_w;
    logic                  out_free;
    logic                  wr_en;
    logic                  seed_en;
    logic                  nxt_we;
    logic                  commit_en;
    ecrs_win_t             win;
    logic [WORD_BITS-1:0]  emit_word;
    logic [WORD_BITS-1:0]  nxt_word;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_reg   <= RULE_RESET;
            active_reg <= ACTIVE_RESET;
        end else if (cfg_valid) begin
            case (ecrs_reg_t'(cfg_index))
                REG_RULE:   rule_reg   <= cfg_data[RULE_W-1:0];
                REG_ACTIVE: active_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Ring length, held as n-1
    assign act_m1 = active_reg - ACTIVE_W'(1);
    assign n_m1   = (active_reg == '0)          ? '0 :
                    (active_reg > ROW_LIMIT_W)  ? CELL_IDX_W'(ROW_LIMIT - 1) :
                                                  act_m1[CELL_IDX_W-1:0];
    assign n_len  = {1'b0, n_m1} + ACTIVE_W'(1);
    assign last_w = n_m1[7:6];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign cmd      = ecrs_cmd_t'(s_tuser);
    assign wr_en    = s_acc && (cmd == CMD_WRITE) &&
                      ({1'b0, s_tdata[CELL_IDX_W-1:0]} < ROW_LIMIT_W);
    assign seed_en  = s_acc && (cmd == CMD_SEED);
    assign out_free = !m_tvalid_reg || m_tready;

    ecrs_row_store #(
        .ROW_LIMIT (ROW_LIMIT)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_idx    (s_tdata[CELL_IDX_W-1:0]),
        .wr_val    (s_tdata[CELL_IDX_W]),
        .seed_en   (seed_en),
        .seed_idx  (n_len[ACTIVE_W-1:1]),
        .commit_en (commit_en),
        .nxt_we    (nxt_we),
        .sel_word  (word_reg),
        .nxt_word  (nxt_word),
        .n_m1      (n_m1),
        .win       (win)
    );

    ecrs_word_unit u_unit (
        .sel_word  (word_reg),
        .win       (win),
        .n_m1      (n_m1),
        .rule      (rule_reg),
        .emit_word (emit_word),
        .nxt_word  (nxt_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            word_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            word_reg     <= word_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    always_comb begin
        state_next    = state_reg;
        word_next     = word_reg;
        nxt_we        = 1'b0;
        commit_en     = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && cmd == CMD_EMIT) begin
                    state_next = ST_EMIT;
                    word_next  = '0;
                end
            end
            ST_EMIT: begin
                // advance one word each time the output slot frees up
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = emit_word;
                    m_tuser_next  = word_reg;
                    m_tlast_next  = (word_reg == last_w);
                    nxt_we        = 1'b1;
                    word_next     = word_reg + WORD_IDX_W'(1);
                    if (word_reg == last_w) begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_COMMIT: begin
                commit_en  = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `ECRS_ASSERT_NEXT(a_emit_starts_at_word0, aclk, aresetn,
        s_acc && cmd == CMD_EMIT, state_reg == ST_EMIT && word_reg == '0)
    `ECRS_ASSERT_NEXT(a_last_word_commits, aclk, aresetn,
        state_reg == ST_EMIT && out_free && word_reg == last_w, state_reg == ST_COMMIT)
    `ECRS_ASSERT_IMPL(a_tlast_matches_length, aclk, aresetn,
        m_tvalid_reg, m_tlast_reg == (m_tuser_reg == last_w))
    `ECRS_ASSERT_IMPL(a_commit_only_after_emit, aclk, aresetn,
        commit_en, $past(state_reg) == ST_EMIT)

endmodule

// File: rtl/core/ecrs_row_store.sv
// Cell row storage, next-generation buffer and word window selection
module ecrs_row_store #(
    parameter int ROW_LIMIT = 256
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    wr_en,
    input  logic [ecrs_pkg::CELL_IDX_W-1:0]         wr_idx,
    input  logic                                    wr_val,
    input  logic                                    seed_en,
    input  logic [ecrs_pkg::CELL_IDX_W-1:0]         seed_idx,
    input  logic                                    commit_en,
    input  logic                                    nxt_we,
    input  logic [ecrs_pkg::WORD_IDX_W-1:0]         sel_word,
    input  logic [ecrs_pkg::WORD_BITS-1:0]          nxt_word,
    input  logic [ecrs_pkg::CELL_IDX_W-1:0]         n_m1,
    output ecrs_pkg::ecrs_win_t                     win
);
    import ecrs_pkg::*;

    logic [ROW_LIMIT-1:0] row_reg;
    logic [ROW_LIMIT-1:0] row_next;
    logic [ROW_LIMIT-1:0] nxt_reg;
    logic [ROW_LIMIT-1:0] nxt_next;
    logic [ROW_BITS-1:0]  row_full;
    logic                 tail;

    genvar g;
    generate
        for (g = 0; g < ROW_LIMIT; g++) begin : g_cell
            localparam logic [CELL_IDX_W-1:0] CI = CELL_IDX_W'(g);
            assign row_next[g] = seed_en                     ? (seed_idx == CI) :
                                 (wr_en && wr_idx == CI)     ? wr_val :
                                 (commit_en && CI <= n_m1)   ? nxt_reg[g] :
                                                               row_reg[g];
            assign nxt_next[g] = (nxt_we && sel_word == CI[7:6]) ? nxt_word[CI[5:0]]
                                                                 : nxt_reg[g];
        end
        for (g = 0; g < ROW_BITS; g++) begin : g_full
            if (g < ROW_LIMIT) begin : g_live
                assign row_full[g] = row_reg[g];
            end else begin : g_pad
                assign row_full[g] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else begin
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        nxt_reg <= nxt_next;
    end

    // left of cell 0 wraps to the last ring cell
    assign tail = row_full[n_m1];

    always_comb begin
        win.head = row_full[0];
        case (sel_word)
            2'd0: begin
                win.word  = row_full[63:0];
                win.left  = tail;
                win.right = row_full[64];
            end
            2'd1: begin
                win.word  = row_full[127:64];
                win.left  = row_full[63];
                win.right = row_full[128];
            end
            2'd2: begin
                win.word  = row_full[191:128];
                win.left  = row_full[127];
                win.right = row_full[192];
            end
            2'd3: begin
                win.word  = row_full[255:192];
                win.left  = row_full[191];
                win.right = 1'b0;
            end
            default: begin
                win.word  = '0;
                win.left  = 1'b0;
                win.right = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/ecrs_word_unit.sv
// Shared 64-cell rule unit: masks one word for output and computes its next generation
module ecrs_word_unit (
    input  logic [ecrs_pkg::WORD_IDX_W-1:0] sel_word,
    input  ecrs_pkg::ecrs_win_t             win,
    input  logic [ecrs_pkg::CELL_IDX_W-1:0] n_m1,
    input  logic [ecrs_pkg::RULE_W-1:0]     rule,
    output logic [ecrs_pkg::WORD_BITS-1:0]  emit_word,
    output logic [ecrs_pkg::WORD_BITS-1:0]  nxt_word
);
    import ecrs_pkg::*;

    logic [WORD_BITS+1:0]  ext;
    logic [CELL_IDX_W-1:0] c;
    logic                  live;
    logic                  r;
    logic [2:0]            hood;

    always_comb begin
        ext       = {win.right, win.word, win.left};
        c         = '0;
        live      = 1'b0;
        r         = 1'b0;
        hood      = '0;
        emit_word = '0;
        nxt_word  = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            c    = {sel_word, 6'(b)};
            live = (c <= n_m1);
            // right of the last ring cell wraps to cell 0
            r    = (c == n_m1) ? win.head : ext[b+2];
            hood = {ext[b], ext[b+1], r};
            emit_word[b] = live & ext[b+1];
            nxt_word[b]  = live ? rule[hood] : ext[b+1];
        end
    end

endmodule

// File: tb/sv/tb_elementary_ca_ring_step_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the elementary CA ring step core with its own ring predictor
module tb_elementary_ca_ring_step_core;
    import ecrs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [1:0]           CMD_NOP     = 2'd3;
    localparam int ROW_CELLS     = 256;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RAND_PHASES   = 9;
    localparam int PHASE_ITEMS   = 22;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] idx;
        logic       val;
    } ca_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0]  word;
        logic [WORD_IDX_W-1:0] num;
        logic                  last;
    } row_word_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [WORD_BITS-1:0]  m_tdata;
    logic [WORD_IDX_W-1:0] m_tuser;
    logic                  m_tlast;

    // Predicted ring and its settings
    logic [ROW_CELLS-1:0]  ring_cells  = '0;
    logic [RULE_W-1:0]     ring_rule   = RULE_RESET;
    logic [ACTIVE_W-1:0]   ring_active = ACTIVE_RESET;

    ca_item_t   items_pending[$];
    row_word_t  row_words_due[$];
    ca_item_t   drv_item;
    idle_mode_t idle_mode = IDLE_NONE;

    logic s_fire   = 1'b0;
    logic cfg_fire = 1'b0;
    int   items_queued  = 0;
    int   items_taken   = 0;
    int   words_checked = 0;
    int   errors        = 0;
    int   stall_cycles  = 0;
    int   n_emit = 0, n_write = 0, n_seed = 0, n_nop = 0, n_cfg = 0;

    logic [7:0] phase_rules [0:RAND_PHASES-1] =
        '{8'd0, 8'd255, 8'd30, 8'd90, 8'd110, 8'd150, 8'd0, 8'd0, 8'd184};
    logic [8:0] phase_active [0:RAND_PHASES-1] =
        '{9'd1, 9'd2, 9'd3, 9'd64, 9'd65, 9'd256, 9'd511, 9'd0, 9'd129};

    elementary_ca_ring_step_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned clamp_len(logic [ACTIVE_W-1:0] active);
        if (active < 1) return 1;
        if (active > ROW_CELLS) return ROW_CELLS;
        return active;
    endfunction

    function automatic bit pause_now(bit sender_side);
        case (idle_mode)
            IDLE_SENDER:   return sender_side && ($urandom_range(99) < 82);
            IDLE_RECEIVER: return !sender_side && ($urandom_range(99) < 82);
            IDLE_BOTH:     return $urandom_range(99) < 9;
            default:       return 1'b0;
        endcase
    endfunction

    // Update the predicted ring for one item and queue the row words it emits
    task automatic apply_item(ca_item_t it);
        int unsigned n, nwords, w, b, c, l, r;
        row_word_t rw;
        logic [ROW_CELLS-1:0] nxt;
        logic [2:0] hood;
        n = clamp_len(ring_active);
        case (it.cmd)
            CMD_WRITE: begin
                ring_cells[it.idx] = it.val;
                n_write++;
            end
            CMD_SEED: begin
                ring_cells = '0;
                ring_cells[n / 2] = 1'b1;
                n_seed++;
            end
            CMD_EMIT: begin
                nwords = (n + WORD_BITS - 1) / WORD_BITS;
                for (w = 0; w < nwords; w++) begin
                    rw.word = '0;
                    for (b = 0; b < WORD_BITS; b++) begin
                        c = w * WORD_BITS + b;
                        if (c < n) rw.word[b] = ring_cells[c];
                    end
                    rw.num  = 2'(w);
                    rw.last = (w + 1 == nwords);
                    row_words_due.push_back(rw);
                end
                // all ring cells step together; cells past the ring hold
                nxt = ring_cells;
                for (c = 0; c < n; c++) begin
                    l = (c == 0) ? n - 1 : c - 1;
                    r = (c == n - 1) ? 0 : c + 1;
                    hood = {ring_cells[l], ring_cells[c], ring_cells[r]};
                    nxt[c] = ring_rule[hood];
                end
                ring_cells = nxt;
                n_emit++;
            end
            default: n_nop++;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    // Driver: present the next pending item unless the sender idles
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (items_pending.size() != 0 && !pause_now(1'b1)) begin
                drv_item = items_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, drv_item.val, drv_item.idx};
                s_tuser  <= drv_item.cmd;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= aresetn && !pause_now(1'b0);
    end

    // Monitor: check results first, then predict from the item taken at this edge
    always @(posedge aclk) begin
        row_word_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (row_words_due.size() == 0) begin
                    report_mismatch("row word with none expected", m_tdata, 0);
                end else begin
                    want = row_words_due.pop_front();
                    if (m_tdata !== want.word) report_mismatch("row_word", m_tdata, want.word);
                    if (m_tuser !== want.num) report_mismatch("word_number", m_tuser, want.num);
                    if (m_tlast !== want.last) report_mismatch("last_word", m_tlast, want.last);
                    words_checked++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RULE:   ring_rule   = cfg_data[RULE_W-1:0];
                    REG_ACTIVE: ring_active = cfg_data;
                    default: ;
                endcase
                n_cfg++;
            end
            if (s_tvalid && s_tready) begin
                apply_item({s_tuser, s_tdata[7:0], s_tdata[8]});
                items_taken++;
            end
        end
        s_fire   <= aresetn && s_tvalid && s_tready;
        cfg_fire <= aresetn && cfg_valid && cfg_ready;
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[%0t] watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic queue_item(logic [1:0] cmd, logic [7:0] idx, logic val);
        ca_item_t it;
        it.cmd = cmd;
        it.idx = idx;
        it.val = val;
        items_pending.push_back(it);
        items_queued++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge aclk); while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge aclk); while (items_taken != items_queued || row_words_due.size() != 0);
    endtask

    // Drain, then let the core finish any item that leaves no result behind
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Mostly emits and in-ring writes, with seeds and unused commands mixed in
    task automatic queue_random(int unsigned n);
        int unsigned pick;
        logic [7:0] idx;
        pick = $urandom_range(99);
        idx  = 8'($urandom);
        if (pick < 40) begin
            queue_item(CMD_EMIT, idx, 1'($urandom));
        end else if (pick < 80) begin
            if ($urandom_range(3) != 0) idx = 8'($urandom_range(n - 1));
            queue_item(CMD_WRITE, idx, 1'($urandom));
        end else if (pick < 92) begin
            queue_item(CMD_SEED, idx, 1'($urandom));
        end else begin
            queue_item(CMD_NOP, idx, 1'($urandom));
        end
    endtask

    initial begin
        int ph, k;
        int unsigned n;
        logic [7:0] rule_sel;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: dead row, centre seed, wrap at both ends, unused command
        @(posedge aclk);
        idle_mode = IDLE_NONE;
        queue_item(CMD_EMIT, 8'h00, 1'b0);
        queue_item(CMD_SEED, 8'h00, 1'b0);
        queue_item(CMD_EMIT, 8'h00, 1'b0);
        queue_item(CMD_EMIT, 8'hFF, 1'b1);
        queue_item(CMD_WRITE, 8'h00, 1'b1);
        queue_item(CMD_WRITE, 8'hFF, 1'b1);
        queue_item(CMD_WRITE, 8'h80, 1'b0);
        queue_item(CMD_EMIT, 8'h00, 1'b0);
        queue_item(CMD_NOP, 8'hFF, 1'b1);
        queue_item(CMD_EMIT, 8'h00, 1'b0);
        queue_item(CMD_WRITE, 8'hAA, 1'b1);
        queue_item(CMD_WRITE, 8'h55, 1'b0);
        queue_item(CMD_EMIT, 8'h00, 1'b0);
        settle();

        // One-cell ring: the cell is its own neighbour; a cell past the ring stays hidden
        write_reg(REG_RULE, 9'd1);
        write_reg(REG_ACTIVE, 9'd1);
        @(posedge aclk);
        queue_item(CMD_EMIT, 8'h00, 1'b0);
        queue_item(CMD_SEED, 8'h00, 1'b0);
        queue_item(CMD_WRITE, 8'd200, 1'b1);
        queue_item(CMD_EMIT, 8'h00, 1'b0);
        queue_item(CMD_EMIT, 8'h00, 1'b0);
        settle();

        // Two-cell ring: both neighbours are the other cell
        write_reg(REG_RULE, 9'd57);
        write_reg(REG_ACTIVE, 9'd2);
        @(posedge aclk);
        queue_item(CMD_WRITE, 8'h01, 1'b1);
        queue_item(CMD_EMIT, 8'h00, 1'b0);
        queue_item(CMD_EMIT, 8'h00, 1'b0);
        queue_item(CMD_WRITE, 8'h00, 1'b1);
        queue_item(CMD_EMIT, 8'h00, 1'b0);
        settle();

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            rule_sel = (ph == 6 || ph == 7) ? 8'($urandom) : phase_rules[ph];
            write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, 9'($urandom));
            write_reg(REG_RULE, {1'($urandom), rule_sel});
            write_reg(REG_ACTIVE, phase_active[ph]);
            n = clamp_len(phase_active[ph]);
            @(posedge aclk);
            idle_mode = idle_mode_t'(ph % 4);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // hold the sender until every row word so far has come back
                if (ph % 3 == 1 && k == PHASE_ITEMS / 2) begin
                    wait_drained();
                    @(posedge aclk);
                end
                queue_random(n);
            end
            settle();
        end

        $display("Ran %0d items: %0d row emits, %0d cell writes, %0d seeds, %0d unused commands",
                 items_taken, n_emit, n_write, n_seed, n_nop);
        $display("Checked %0d row words across %0d register writes, ring lengths 1 to 256",
                 words_checked, n_cfg);
        if (errors == 0 && row_words_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: elementary_ca_ring_step_core.f
+incdir+rtl/core
rtl/core/ecrs_pkg.sv
rtl/core/ecrs_row_store.sv
rtl/core/ecrs_word_unit.sv
rtl/core/elementary_ca_ring_step_core.sv
tb/sv/tb_elementary_ca_ring_step_core.sv
